@@ hw/rtl/bzf_pkg.sv @@
`default_nettype none
package bzf_pkg;

  // Fraction bits of every pixel quantity
  localparam int PIX_FRAC = 4;

  // Image size in pixel LSBs, and signed width of doubled coordinates
  localparam int WL = 13 + PIX_FRAC;
  localparam int CW = ((WL + 1 > 19) ? WL + 1 : 19) + 2;
  // Product of reference zoom and a ratio numerator
  localparam int RW = CW + 16;
  // Quotient bits needed before clamping to the zoom limit
  localparam int QB = 13;

  localparam logic [12:0] ZOOM_MIN_Q = 13'd256;
  localparam logic [12:0] ZOOM_MAX_Q = 13'd7680;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_OPT_CENTER_X = 3'd2;
  localparam logic [2:0] REG_OPT_CENTER_Y = 3'd3;
  localparam logic [2:0] REG_FIT_FRACTION = 3'd4;
  localparam logic [2:0] REG_EDGE_BAND    = 3'd5;

  typedef enum logic [1:0] {
    ST_FITTED   = 2'd0,
    ST_DEGEN    = 2'd1,
    ST_BORDER   = 2'd2,
    ST_NO_LIMIT = 2'd3
  } bzf_status_t;

  typedef struct packed {
    logic [16:0] box_center_x;
    logic [16:0] box_center_y;
    logic [16:0] box_width;
    logic [16:0] box_height;
    logic [15:0] reference_zoom_q;
  } bzf_in_t;

  typedef struct packed {
    logic [12:0] fitted_zoom;
    logic [1:0]  fit_status;
  } bzf_out_t;

  // Clamp a Q8.8 zoom to 1.0 .. 30.0
  function automatic logic [12:0] clamp_zoom(input logic [15:0] z);
    logic [12:0] r;
    if (z < 16'(ZOOM_MIN_Q)) begin
      r = ZOOM_MIN_Q;
    end else if (z > 16'(ZOOM_MAX_Q)) begin
      r = ZOOM_MAX_Q;
    end else begin
      r = z[12:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/bbox_zoom_fit_calculator_unit.sv @@
// Zoom-to-fit calculator, fully pipelined.
// Throughput: one box per cycle while the output is not stalled; the 13-stage restoring divider sets the depth.
// A stall at the output holds every stage in place.
// Synchronous reset clears all valid bits and loads the register defaults.
`default_nettype none
module bbox_zoom_fit_calculator_unit
  import bzf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire bzf_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output bzf_out_t         out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [16:0] cfg_data
);

  // Configuration registers
  logic [12:0] img_width;
  logic [12:0] img_height;
  logic [16:0] optical_center_x;
  logic [16:0] optical_center_y;
  logic [15:0] fit_fraction;
  logic [11:0] edge_band;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      img_width        <= 13'd1920;
      img_height       <= 13'd1080;
      optical_center_x <= 17'd15360;
      optical_center_y <= 17'd8640;
      fit_fraction     <= 16'd45875;
      edge_band        <= 12'd160;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  img_width        <= cfg_data[12:0];
        REG_IMAGE_HEIGHT: img_height       <= cfg_data[12:0];
        REG_OPT_CENTER_X: optical_center_x <= cfg_data;
        REG_OPT_CENTER_Y: optical_center_y <= cfg_data;
        REG_FIT_FRACTION: fit_fraction     <= cfg_data[15:0];
        REG_EDGE_BAND:    edge_band        <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // Whole pipeline advances together; the last stage is the output register
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Frame constants in doubled coordinates
  logic        [WL-1:0] wl;
  logic        [WL-1:0] hl;
  logic signed [CW-1:0] w2;
  logic signed [CW-1:0] h2;
  logic signed [CW-1:0] cx2;
  logic signed [CW-1:0] cy2;
  logic signed [CW-1:0] band2;
  logic        [16:0]   room;
  logic        [16+WL:0] mprod_x;
  logic        [16+WL:0] mprod_y;

  assign wl    = WL'(img_width) << PIX_FRAC;
  assign hl    = WL'(img_height) << PIX_FRAC;
  assign w2    = $signed(CW'({wl, 1'b0}));
  assign h2    = $signed(CW'({hl, 1'b0}));
  assign cx2   = $signed(CW'({optical_center_x, 1'b0}));
  assign cy2   = $signed(CW'({optical_center_y, 1'b0}));
  assign band2 = $signed(CW'({edge_band, 1'b0}));
  assign room  = 17'h10000 - {1'b0, fit_fraction};
  assign mprod_x = room * wl;
  assign mprod_y = room * hl;

  // Stage 1: box edges, margins, bypass classification
  logic signed [CW-1:0] e_left;
  logic signed [CW-1:0] e_right;
  logic signed [CW-1:0] e_top;
  logic signed [CW-1:0] e_bottom;
  logic                 degen;
  logic                 touch;

  assign e_left   = $signed(CW'({in_data.box_center_x, 1'b0})) - $signed(CW'(in_data.box_width));
  assign e_right  = $signed(CW'({in_data.box_center_x, 1'b0})) + $signed(CW'(in_data.box_width));
  assign e_top    = $signed(CW'({in_data.box_center_y, 1'b0})) - $signed(CW'(in_data.box_height));
  assign e_bottom = $signed(CW'({in_data.box_center_y, 1'b0})) + $signed(CW'(in_data.box_height));
  assign degen    = (img_width <= 13'd1) || (img_height <= 13'd1);
  assign touch    = (e_left <= band2) || (e_top <= band2) ||
                    (e_right >= w2 - band2) || (e_bottom >= h2 - band2);

  logic                 s1_valid;
  logic signed [CW-1:0] s1_left;
  logic signed [CW-1:0] s1_right;
  logic signed [CW-1:0] s1_top;
  logic signed [CW-1:0] s1_bottom;
  logic signed [CW-1:0] s1_mx2;
  logic signed [CW-1:0] s1_my2;
  logic [15:0]          s1_ref;
  logic                 s1_bypass;
  bzf_status_t          s1_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_left   <= e_left;
      s1_right  <= e_right;
      s1_top    <= e_top;
      s1_bottom <= e_bottom;
      s1_mx2    <= $signed(CW'(mprod_x[16+WL:16]));
      s1_my2    <= $signed(CW'(mprod_y[16+WL:16]));
      s1_ref    <= in_data.reference_zoom_q;
      s1_bypass <= degen || touch;
      if (degen) begin
        s1_status <= ST_DEGEN;
      end else if (touch) begin
        s1_status <= ST_BORDER;
      end else begin
        s1_status <= ST_FITTED;
      end
    end
  end

  // Stage 2: ratio numerators, divisors and use flags for the left, right, top and bottom edges
  logic                 s2_valid;
  logic signed [CW-1:0] s2_n [4];
  logic signed [CW-1:0] s2_d [4];
  logic [3:0]           s2_use;
  logic [15:0]          s2_ref;
  logic                 s2_bypass;
  bzf_status_t          s2_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_use[0] <= s1_left < cx2;
      s2_n[0]   <= cx2 - s1_mx2;
      s2_d[0]   <= cx2 - s1_left;
      s2_use[1] <= s1_right > cx2;
      s2_n[1]   <= (w2 - s1_mx2) - cx2;
      s2_d[1]   <= s1_right - cx2;
      s2_use[2] <= s1_top < cy2;
      s2_n[2]   <= cy2 - s1_my2;
      s2_d[2]   <= cy2 - s1_top;
      s2_use[3] <= s1_bottom > cy2;
      s2_n[3]   <= (h2 - s1_my2) - cy2;
      s2_d[3]   <= s1_bottom - cy2;
      s2_ref    <= s1_ref;
      s2_bypass <= s1_bypass;
      s2_status <= s1_status;
    end
  end

  // Stage 3: smaller ratio of each axis pair; when both edges apply, the later one wins only if strictly smaller
  logic signed [2*CW-1:0] xp_a;
  logic signed [2*CW-1:0] xp_b;
  logic signed [2*CW-1:0] yp_a;
  logic signed [2*CW-1:0] yp_b;
  logic                   pick_x1;
  logic                   pick_y1;

  assign xp_a    = s2_n[1] * s2_d[0];
  assign xp_b    = s2_n[0] * s2_d[1];
  assign yp_a    = s2_n[3] * s2_d[2];
  assign yp_b    = s2_n[2] * s2_d[3];
  assign pick_x1 = s2_use[1] && (!s2_use[0] || (xp_a < xp_b));
  assign pick_y1 = s2_use[3] && (!s2_use[2] || (yp_a < yp_b));

  logic                 s3_valid;
  logic signed [CW-1:0] s3_nx;
  logic signed [CW-1:0] s3_dx;
  logic signed [CW-1:0] s3_ny;
  logic signed [CW-1:0] s3_dy;
  logic                 s3_hx;
  logic                 s3_hy;
  logic [15:0]          s3_ref;
  logic                 s3_bypass;
  bzf_status_t          s3_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_nx     <= pick_x1 ? s2_n[1] : s2_n[0];
      s3_dx     <= pick_x1 ? s2_d[1] : s2_d[0];
      s3_hx     <= s2_use[0] || s2_use[1];
      s3_ny     <= pick_y1 ? s2_n[3] : s2_n[2];
      s3_dy     <= pick_y1 ? s2_d[3] : s2_d[2];
      s3_hy     <= s2_use[2] || s2_use[3];
      s3_ref    <= s2_ref;
      s3_bypass <= s2_bypass;
      s3_status <= s2_status;
    end
  end

  // Stage 4: overall smallest ratio
  logic signed [2*CW-1:0] fp_a;
  logic signed [2*CW-1:0] fp_b;
  logic                   pick_y;

  assign fp_a   = s3_ny * s3_dx;
  assign fp_b   = s3_nx * s3_dy;
  assign pick_y = s3_hy && (!s3_hx || (fp_a < fp_b));

  logic                 s4_valid;
  logic signed [CW-1:0] s4_n;
  logic signed [CW-1:0] s4_d;
  logic                 s4_have;
  logic [15:0]          s4_ref;
  logic                 s4_bypass;
  bzf_status_t          s4_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (adv) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_n      <= pick_y ? s3_ny : s3_nx;
      s4_d      <= pick_y ? s3_dy : s3_dx;
      s4_have   <= s3_hx || s3_hy;
      s4_ref    <= s3_ref;
      s4_bypass <= s3_bypass;
      s4_status <= s3_status;
    end
  end

  // Stage 5: product, saturation check, final bypass decision
  logic [RW-1:0] prod;
  logic [RW-1:0] d_wide;
  logic          n_pos;

  assign n_pos  = s4_n > $signed(CW'(0));
  assign prod   = RW'(s4_ref) * RW'(s4_n[CW-2:0]);
  assign d_wide = RW'(s4_d[CW-2:0]);

  logic             dv_valid  [QB+1];
  logic [RW-1:0]    dv_rem    [QB+1];
  logic [CW-2:0]    dv_d      [QB+1];
  logic [QB-1:0]    dv_q      [QB+1];
  logic             dv_sat    [QB+1];
  logic             dv_bypass [QB+1];
  logic [12:0]      dv_bzoom  [QB+1];
  bzf_status_t      dv_status [QB+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else if (adv) begin
      dv_valid[0] <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_rem[0]    <= prod;
      dv_d[0]      <= s4_d[CW-2:0];
      dv_q[0]      <= '0;
      dv_sat[0]    <= prod >= (d_wide << QB);
      dv_bypass[0] <= s4_bypass || !s4_have || !n_pos;
      dv_bzoom[0]  <= clamp_zoom(s4_ref);
      if (s4_bypass) begin
        dv_status[0] <= s4_status;
      end else if (!s4_have) begin
        dv_status[0] <= ST_NO_LIMIT;
      end else begin
        dv_status[0] <= ST_FITTED;
      end
    end
  end

  // Restoring divider, one quotient bit per stage, most significant first
  for (genvar s = 0; s < QB; s++) begin : g_div
    logic [RW-1:0] dsh;
    logic          take;

    assign dsh  = RW'(dv_d[s]) << (QB - 1 - s);
    assign take = dv_rem[s] >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[s+1] <= 1'b0;
      end else if (adv) begin
        dv_valid[s+1] <= dv_valid[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem[s+1]    <= take ? dv_rem[s] - dsh : dv_rem[s];
        dv_d[s+1]      <= dv_d[s];
        dv_q[s+1]      <= dv_q[s] | (QB'(take) << (QB - 1 - s));
        dv_sat[s+1]    <= dv_sat[s];
        dv_bypass[s+1] <= dv_bypass[s];
        dv_bzoom[s+1]  <= dv_bzoom[s];
        dv_status[s+1] <= dv_status[s];
      end
    end
  end

  // Output register: pick bypass zoom, saturated limit or clamped quotient
  logic [12:0] fit_zoom;

  always_comb begin
    if (dv_bypass[QB]) begin
      fit_zoom = dv_bzoom[QB];
    end else if (dv_sat[QB]) begin
      fit_zoom = ZOOM_MAX_Q;
    end else begin
      fit_zoom = clamp_zoom(16'(dv_q[QB]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_valid[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.fitted_zoom <= fit_zoom;
      out_data.fit_status  <= dv_status[QB];
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/bzf_checker.sv @@
`default_nettype none
module bzf_checker
  import bzf_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     in_ready,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire bzf_out_t out_data
);

  // Held result stays put until transferred
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Zoom always within limits
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.fitted_zoom >= ZOOM_MIN_Q) &&
                  (out_data.fitted_zoom <= ZOOM_MAX_Q))
    else $error("zoom out of range");

  // Input side never blocks while the output side is free
  a_flow: assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with free output");

  // Reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind bbox_zoom_fit_calculator_unit bzf_checker u_bzf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
